### hdl/soft_clip_waveshaper_core_macros.svh
// Assertion helpers for the waveshaper checker.
`ifndef SOFT_CLIP_WAVESHAPER_CORE_MACROS_SVH
`define SOFT_CLIP_WAVESHAPER_CORE_MACROS_SVH

// Check a property outside reset.
`define SCW_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scw check failed");

// Check a property at every edge, reset included.
`define SCW_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("scw check failed");

`endif

### hdl/scw_pkg.sv
package scw_pkg;

   typedef enum logic [1:0] {
      SHAPE_TANH   = 2'd0,
      SHAPE_CUBIC  = 2'd1,
      SHAPE_HARD   = 2'd2,
      SHAPE_BYPASS = 2'd3
   } shape_type;

   // Per-item control that rides along the pipeline.
   typedef struct packed {
      logic      neg;
      shape_type mode;
   } tag_type;

   localparam int TANH_NUM_K = 27;
   localparam int TANH_DEN_K = 9;
   localparam int TANH_LIMIT = 3;
   localparam int CUBE_DIV   = 3;

endpackage

### hdl/scw_div_cell.sv
module scw_div_cell #(
   parameter int FRAC_BITS   = 12,
   parameter int SAMPLE_BITS = 16,
   parameter int SHIFT       = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  scw_pkg::tag_type                       in_tag,
   input  logic [2*FRAC_BITS+6:0]                 in_rem,
   input  logic [FRAC_BITS+6:0]                   in_den,
   input  logic [FRAC_BITS+1:0]                   in_quo,
   input  logic [((SAMPLE_BITS > FRAC_BITS+2) ? SAMPLE_BITS : FRAC_BITS+2)-1:0] in_aux,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output scw_pkg::tag_type                       out_tag,
   output logic [2*FRAC_BITS+6:0]                 out_rem,
   output logic [FRAC_BITS+6:0]                   out_den,
   output logic [FRAC_BITS+1:0]                   out_quo,
   output logic [((SAMPLE_BITS > FRAC_BITS+2) ? SAMPLE_BITS : FRAC_BITS+2)-1:0] out_aux
);
   import scw_pkg::*;

   localparam int DW = FRAC_BITS + 7;
   localparam int NW = 2*FRAC_BITS + 7;
   localparam int QW = FRAC_BITS + 2;
   localparam int AW = (SAMPLE_BITS > FRAC_BITS+2) ? SAMPLE_BITS : FRAC_BITS+2;

   logic          valid_ff, valid_in;
   tag_type       tag_ff;
   logic [NW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff;
   logic [QW-1:0] quo_ff, quo_in;
   logic [AW-1:0] aux_ff;
   logic [NW:0]   den_sh;
   logic          take;

   // One restoring step: try the shifted divisor against the remainder.
   assign den_sh = {{(NW+1-DW){1'b0}}, in_den} << SHIFT;
   assign take   = ({1'b0, in_rem} >= den_sh);
   assign rem_in = take ? (in_rem - den_sh[NW-1:0]) : in_rem;
   assign quo_in = {in_quo[QW-2:0], take};

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         tag_ff <= in_tag;
         rem_ff <= rem_in;
         den_ff <= in_den;
         quo_ff <= quo_in;
         aux_ff <= in_aux;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_aux   = aux_ff;

endmodule

### hdl/scw_front.sv
module scw_front #(
   parameter int FRAC_BITS   = 12,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  scw_pkg::shape_type                     mode,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [SAMPLE_BITS-1:0]                 in_sample,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output scw_pkg::tag_type                       out_tag,
   output logic [2*FRAC_BITS+6:0]                 out_rem,
   output logic [FRAC_BITS+6:0]                   out_den,
   output logic [((SAMPLE_BITS > FRAC_BITS+2) ? SAMPLE_BITS : FRAC_BITS+2)-1:0] out_aux
);
   import scw_pkg::*;

   localparam int F    = FRAC_BITS;
   localparam int S    = SAMPLE_BITS;
   localparam int MW   = F + 2;
   localparam int SQW  = F + 4;
   localparam int TW   = F + 6;
   localparam int DW   = F + 7;
   localparam int NW   = 2*F + 7;
   localparam int CW   = F + 1;
   localparam int KW   = F + 2;
   localparam int AW   = (S > F+2) ? S : F+2;
   localparam int LW   = (S > F+2) ? S : F+2;
   localparam int PW2  = 2*MW;
   localparam int PW3  = SQW + MW;
   localparam int PW4  = MW + TW;
   localparam int PW4C = CW + KW;
   localparam int NST  = 5;

   localparam logic [LW-1:0]   ONE_L    = LW'(1) << F;
   localparam logic [LW-1:0]   LIM3_L   = LW'(TANH_LIMIT) << F;
   localparam logic [PW2-1:0]  HALF_2   = PW2'(1) << (F-1);
   localparam logic [PW3-1:0]  HALF_3   = PW3'(1) << (F-1);
   localparam logic [PW4-1:0]  HALF_4   = PW4'(1) << (F-1);
   localparam logic [TW-1:0]   K27_T    = TW'(TANH_NUM_K) << F;
   localparam logic [DW-1:0]   K27_D    = DW'(TANH_NUM_K) << F;
   localparam logic [KW-1:0]   RECIP3   = KW'((64'd1 << (FRAC_BITS+3)) / CUBE_DIV);

   logic [NST-1:0] vld_ff, vld_in, adv;

   // stage 1: magnitude and clamp
   logic [S-1:0]   mag_c;
   logic [LW-1:0]  mag_l, lim_l, clamp_l;
   tag_type        tag1_ff, tag1_in;
   logic [MW-1:0]  m1_ff, m1_in;
   logic [S-1:0]   mag1_ff;
   // stage 2: square
   logic [PW2-1:0] p2;
   tag_type        tag2_ff;
   logic [MW-1:0]  m2_ff;
   logic [S-1:0]   mag2_ff;
   logic [SQW-1:0] sq2_ff, sq2_in;
   // stage 3: tanh sum, denominator, cube
   logic [PW3-1:0] p3;
   tag_type        tag3_ff;
   logic [MW-1:0]  m3_ff;
   logic [S-1:0]   mag3_ff;
   logic [TW-1:0]  t3_ff, t3_in;
   logic [DW-1:0]  den3_ff, den3_in;
   logic [CW-1:0]  cube3_ff, cube3_in;
   // stage 4: numerator, reciprocal product for the divide by three
   logic [PW4-1:0]  p4;
   tag_type         tag4_ff;
   logic [MW-1:0]   m4_ff;
   logic [S-1:0]    mag4_ff;
   logic [DW-1:0]   num4_ff, num4_in;
   logic [DW-1:0]   den4_ff;
   logic [CW-1:0]   cube4_ff;
   logic [PW4C-1:0] cp4_ff, cp4_in;
   // stage 5: exact third, side result, dividend
   logic [F-1:0]   q0, cq;
   logic [CW-1:0]  trip, resid;
   logic [MW-1:0]  cub;
   tag_type        tag5_ff;
   logic [NW-1:0]  rem5_ff, rem5_in;
   logic [DW-1:0]  den5_ff;
   logic [AW-1:0]  aux5_ff, aux5_in;

   always_comb begin
      adv[NST-1] = !vld_ff[NST-1] || out_ready;
      for (int k = NST-2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < NST; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_ready = adv[0];

   // stage 1
   always_comb begin
      mag_c        = in_sample[S-1] ? (~in_sample + S'(1)) : in_sample;
      mag_l        = LW'(mag_c);
      lim_l        = (mode == SHAPE_TANH) ? LIM3_L : ONE_L;
      clamp_l      = (mag_l > lim_l) ? lim_l : mag_l;
      m1_in        = clamp_l[MW-1:0];
      tag1_in.neg  = in_sample[S-1];
      tag1_in.mode = mode;
   end

   // stage 2
   assign p2     = {{MW{1'b0}}, m1_ff} * {{MW{1'b0}}, m1_ff} + HALF_2;
   assign sq2_in = p2[F+SQW-1:F];

   // stage 3
   assign p3       = {{MW{1'b0}}, sq2_ff} * {{SQW{1'b0}}, m2_ff} + HALF_3;
   assign cube3_in = p3[F+CW-1:F];
   assign t3_in    = K27_T + TW'(sq2_ff);
   assign den3_in  = K27_D + DW'(TANH_DEN_K) * DW'(sq2_ff);

   // stage 4
   assign p4      = {{TW{1'b0}}, m3_ff} * {{MW{1'b0}}, t3_ff} + HALF_4;
   assign num4_in = p4[F+DW-1:F];
   assign cp4_in  = {{KW{1'b0}}, cube3_ff} * {{CW{1'b0}}, RECIP3};

   // stage 5: reciprocal estimate is low by at most one, so fix it with one compare
   always_comb begin
      q0    = cp4_ff[PW4C-1:F+3];
      trip  = CW'(CUBE_DIV) * CW'(q0);
      resid = cube4_ff - trip;
      cq    = q0 + F'(resid >= CW'(CUBE_DIV));
      cub   = m4_ff - MW'(cq);
      unique case (tag4_ff.mode)
         SHAPE_TANH:   aux5_in = '0;
         SHAPE_CUBIC:  aux5_in = AW'(cub);
         SHAPE_HARD:   aux5_in = AW'(m4_ff);
         SHAPE_BYPASS: aux5_in = AW'(mag4_ff);
      endcase
      rem5_in = {num4_ff, {F{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         tag1_ff <= tag1_in;
         m1_ff   <= m1_in;
         mag1_ff <= mag_c;
      end
      if (adv[1]) begin
         tag2_ff <= tag1_ff;
         m2_ff   <= m1_ff;
         mag2_ff <= mag1_ff;
         sq2_ff  <= sq2_in;
      end
      if (adv[2]) begin
         tag3_ff  <= tag2_ff;
         m3_ff    <= m2_ff;
         mag3_ff  <= mag2_ff;
         t3_ff    <= t3_in;
         den3_ff  <= den3_in;
         cube3_ff <= cube3_in;
      end
      if (adv[3]) begin
         tag4_ff  <= tag3_ff;
         m4_ff    <= m3_ff;
         mag4_ff  <= mag3_ff;
         num4_ff  <= num4_in;
         den4_ff  <= den3_ff;
         cube4_ff <= cube3_ff;
         cp4_ff   <= cp4_in;
      end
      if (adv[4]) begin
         tag5_ff <= tag4_ff;
         rem5_ff <= rem5_in;
         den5_ff <= den4_ff;
         aux5_ff <= aux5_in;
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_tag   = tag5_ff;
   assign out_rem   = rem5_ff;
   assign out_den   = den5_ff;
   assign out_aux   = aux5_ff;

endmodule

### hdl/scw_out.sv
module scw_out #(
   parameter int FRAC_BITS   = 12,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  scw_pkg::tag_type                       in_tag,
   input  logic [FRAC_BITS+1:0]                   in_quo,
   input  logic [((SAMPLE_BITS > FRAC_BITS+2) ? SAMPLE_BITS : FRAC_BITS+2)-1:0] in_aux,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [SAMPLE_BITS-1:0]                 rsp_sample
);
   import scw_pkg::*;

   localparam int S  = SAMPLE_BITS;
   localparam int AW = (S > FRAC_BITS+2) ? S : FRAC_BITS+2;

   localparam logic [AW-1:0] NEG_LIM = AW'(1) << (S-1);
   localparam logic [AW-1:0] POS_MAX = NEG_LIM - AW'(1);
   localparam logic [S-1:0]  OUT_MAX = {1'b0, {(S-1){1'b1}}};
   localparam logic [S-1:0]  OUT_MIN = {1'b1, {(S-1){1'b0}}};

   logic          valid_ff, valid_in;
   logic [S-1:0]  out_ff, out_in;
   logic [AW-1:0] mag, mag_neg;

   // Put the sign back and saturate to the sample range.
   always_comb begin
      mag     = (in_tag.mode == SHAPE_TANH) ? AW'(in_quo) : in_aux;
      mag_neg = ~mag + AW'(1);
      if (in_tag.neg) begin
         out_in = (mag > NEG_LIM) ? OUT_MIN : mag_neg[S-1:0];
      end else begin
         out_in = (mag > POS_MAX) ? OUT_MAX : mag[S-1:0];
      end
   end

   assign in_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_sample = out_ff;

endmodule

### hdl/soft_clip_waveshaper_core.sv
// Soft-clip waveshaper: one signed fixed-point sample in, one shaped sample out.
// Input channel req_valid/req_ready carries req_sample_in; result channel
// rsp_valid/rsp_ready carries rsp_sample_out. Both use a plain valid/ready
// handshake; an item moves on an edge where valid and ready are both high.
// The shape comes from csr_wr_data, stored on an edge with csr_wr_en high;
// write it only while no item is in flight.
// Pipeline: five front stages (magnitude and clamp, square, sums and cube,
// numerator, third), one divider cell per quotient bit (FRAC_BITS + 2
// cells), and the sign/saturate output register.
// Throughput: one item per cycle when not stalled; the divider chain is fully
// pipelined and every mode travels the same path, so results leave in order.
// Stall: each stage holds its item while the stage ahead is full and not
// moving; bubbles collapse, so the input keeps taking items while a
// finished result waits at the output as long as some stage is empty.
// Reset: synchronous; clears every stage valid and sets the shape to the
// rational tanh curve. No clearing pass, the block is ready right after.
module soft_clip_waveshaper_core #(
   parameter int FRAC_BITS   = 12,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_wr_data
);
   import scw_pkg::*;

   localparam int DW = FRAC_BITS + 7;
   localparam int NW = 2*FRAC_BITS + 7;
   localparam int QW = FRAC_BITS + 2;
   localparam int AW = (SAMPLE_BITS > FRAC_BITS+2) ? SAMPLE_BITS : FRAC_BITS+2;

   // Shape register: the user must write it only between items; not enforced here.
   shape_type csr_mode_ff, csr_mode_in;

   assign csr_mode_in = csr_wr_en ? shape_type'(csr_wr_data) : csr_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_mode_ff <= SHAPE_TANH;
      end else begin
         csr_mode_ff <= csr_mode_in;
      end
   end

   // Links between front, divider cells and output stage. Index i feeds cell i.
   logic          vld_c [0:QW];
   logic          rdy_c [0:QW];
   tag_type       tag_c [0:QW];
   logic [NW-1:0] rem_c [0:QW-1];
   logic [DW-1:0] den_c [0:QW-1];
   logic [QW-1:0] quo_c [0:QW];
   logic [AW-1:0] aux_c [0:QW];
   logic [SAMPLE_BITS-1:0] rsp_sample;

   // Front: magnitude, clamp, square, numerator and denominator of the tanh
   // curve, and the cubic, hard-clip or bypass magnitude as a side result.
   scw_front #(
      .FRAC_BITS   (FRAC_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .mode      (csr_mode_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_sample (req_sample_in),
      .out_valid (vld_c[0]),
      .out_ready (rdy_c[0]),
      .out_tag   (tag_c[0]),
      .out_rem   (rem_c[0]),
      .out_den   (den_c[0]),
      .out_aux   (aux_c[0])
   );

   // Start every quotient at zero; each cell shifts in one bit, MSB first.
   assign quo_c[0] = '0;

   for (genvar i = 0; i < QW; i++) begin : g_cell
      if (i < QW-1) begin : g_mid
         scw_div_cell #(
            .FRAC_BITS   (FRAC_BITS),
            .SAMPLE_BITS (SAMPLE_BITS),
            .SHIFT       (QW-1-i)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (vld_c[i]),
            .in_ready  (rdy_c[i]),
            .in_tag    (tag_c[i]),
            .in_rem    (rem_c[i]),
            .in_den    (den_c[i]),
            .in_quo    (quo_c[i]),
            .in_aux    (aux_c[i]),
            .out_valid (vld_c[i+1]),
            .out_ready (rdy_c[i+1]),
            .out_tag   (tag_c[i+1]),
            .out_rem   (rem_c[i+1]),
            .out_den   (den_c[i+1]),
            .out_quo   (quo_c[i+1]),
            .out_aux   (aux_c[i+1])
         );
      end else begin : g_last
         // Last quotient bit: the remainder and divisor stop here.
         scw_div_cell #(
            .FRAC_BITS   (FRAC_BITS),
            .SAMPLE_BITS (SAMPLE_BITS),
            .SHIFT       (QW-1-i)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (vld_c[i]),
            .in_ready  (rdy_c[i]),
            .in_tag    (tag_c[i]),
            .in_rem    (rem_c[i]),
            .in_den    (den_c[i]),
            .in_quo    (quo_c[i]),
            .in_aux    (aux_c[i]),
            .out_valid (vld_c[i+1]),
            .out_ready (rdy_c[i+1]),
            .out_tag   (tag_c[i+1]),
            .out_rem   (),
            .out_den   (),
            .out_quo   (quo_c[i+1]),
            .out_aux   (aux_c[i+1])
         );
      end
   end

   // Output register: pick quotient or side result, restore sign, saturate.
   scw_out #(
      .FRAC_BITS   (FRAC_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (vld_c[QW]),
      .in_ready   (rdy_c[QW]),
      .in_tag     (tag_c[QW]),
      .in_quo     (quo_c[QW]),
      .in_aux     (aux_c[QW]),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample)
   );

   assign rsp_sample_out = rsp_sample;

endmodule

### hdl/scw_checker.sv
`include "soft_clip_waveshaper_core_macros.svh"

module scw_checker #(
   parameter int FRAC_BITS   = 12,
   parameter int SAMPLE_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                          csr_wr_en,
   input logic [1:0]                    csr_wr_data
);
   import scw_pkg::*;

   localparam longint ONE_L = longint'(1) << FRAC_BITS;

   shape_type mode_ff, mode_in;
   longint    out_val;
   logic      in_band;
   logic      req_seen;

   // Track the shape as the port shows it.
   assign mode_in = csr_wr_en ? shape_type'(csr_wr_data) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= SHAPE_TANH;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign out_val  = longint'(rsp_sample_out);
   assign in_band  = (out_val <= ONE_L) && (out_val >= -ONE_L);
   assign req_seen = req_valid && req_ready;

   `SCW_ASSERT_ALWAYS(a_reset_clears_output, clock, reset |=> !rsp_valid)
   `SCW_ASSERT(a_stalled_result_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
   `SCW_ASSERT(a_empty_pipe_takes_input, clock, reset, !rsp_valid |-> req_ready)
   `SCW_ASSERT(a_hard_clip_in_band, clock, reset, rsp_valid && mode_ff == SHAPE_HARD |-> in_band)
   `SCW_ASSERT(a_no_result_after_idle_reset, clock, reset, $past(reset) && !req_seen |=> !rsp_valid)

endmodule

bind soft_clip_waveshaper_core scw_checker #(
   .FRAC_BITS   (FRAC_BITS),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_scw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out),
   .csr_wr_en      (csr_wr_en),
   .csr_wr_data    (csr_wr_data)
);

### bench/soft_clip_waveshaper_core_tb.sv
module soft_clip_waveshaper_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import scw_pkg::*;

   localparam int FRAC_BITS   = 12;
   localparam int SAMPLE_BITS = 16;

   // Acceptance to rsp_valid: front stages, divider cells and output register.
   localparam int PIPE_LATENCY   = FRAC_BITS + 8;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 144;
   localparam int SQUEEZE_CYCLES = 160;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam longint unsigned ONE_Q  = 64'd1 << FRAC_BITS;
   localparam longint unsigned HALF_Q = 64'd1 << (FRAC_BITS - 1);
   localparam longint          MAX_S  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint          MIN_S  = -MAX_S - 1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // One directed probe: curve, input, and optionally the result read off by hand.
   typedef struct packed {
      shape_type  shape;
      sample_type sample;
      logic       typed;
      sample_type result;
   } probe_type;

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   sample_type req_sample_in  = '0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   sample_type rsp_sample_out;
   logic       csr_wr_en      = 1'b0;
   logic [1:0] csr_wr_data    = SHAPE_TANH;

   // Shaped samples still owed by the block, oldest first.
   sample_type expected_samples[$];

   // The curve the block holds; reset leaves it on the rational tanh.
   shape_type shape_now       = SHAPE_TANH;

   int  items_sent            = 0;
   int  checked_count         = 0;
   int  error_count           = 0;
   int  shape_writes          = 0;
   int  input_stall_cycles    = 0;
   int  idle_cycles           = 0;
   int  burst_left            = 0;
   bit  squeeze_request       = 1'b0;
   bit  squeeze_done          = 1'b0;
   // Valid is being driven high by the sender.
   bit  valid_up              = 1'b0;

   probe_type probe_table [26];

   soft_clip_waveshaper_core #(
      .FRAC_BITS   (FRAC_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Fixed-point product of two magnitudes, rounded to nearest.
   function automatic longint unsigned round_product(input longint unsigned a,
                                                     input longint unsigned b);
      return (a * b + HALF_Q) >> FRAC_BITS;
   endfunction

   // Predict the block's output for one sample under the given curve.
   // Work on the magnitude, put the sign back, then saturate to the sample range.
   function automatic sample_type shaped_sample(input shape_type shape, input sample_type x);
      longint unsigned raw;
      longint unsigned mag;
      longint unsigned sq;
      longint unsigned num;
      longint unsigned den;
      longint unsigned cube;
      longint unsigned r;
      longint          v;
      logic            neg;
      raw = '0;
      raw[SAMPLE_BITS-1:0] = x;
      neg = x[SAMPLE_BITS-1];
      // The most negative input keeps its full magnitude here.
      mag = neg ? ((64'd1 << SAMPLE_BITS) - raw) : raw;
      case (shape)
         SHAPE_TANH: begin
            if (mag > 3 * ONE_Q) mag = 3 * ONE_Q;
            sq  = round_product(mag, mag);
            num = round_product(mag, 27 * ONE_Q + sq);
            den = 27 * ONE_Q + 9 * sq;
            r   = (num << FRAC_BITS) / den;
         end
         SHAPE_CUBIC: begin
            if (mag > ONE_Q) mag = ONE_Q;
            sq   = round_product(mag, mag);
            cube = round_product(sq, mag);
            r    = mag - cube / 3;
         end
         SHAPE_HARD: begin
            r = (mag > ONE_Q) ? ONE_Q : mag;
         end
         default: begin
            r = mag;
         end
      endcase
      v = neg ? -signed'(r) : signed'(r);
      if (v > MAX_S) v = MAX_S;
      if (v < MIN_S) v = MIN_S;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // Draw a sample, weighted toward the clamp knees and the range corners.
   function automatic sample_type random_sample();
      int value;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: value = $urandom;
         4, 5:       value = 4096 + $urandom_range(0, 64) - 32;
         6:          value = 12288 + $urandom_range(0, 64) - 32;
         7:          value = $urandom_range(0, 8191);
         8: begin
            case ($urandom_range(0, 6))
               0:       value = 0;
               1:       value = 1;
               2:       value = 32767;
               3:       value = 32768;
               4:       value = 4095;
               5:       value = 12289;
               default: value = 4096;
            endcase
         end
         default:    value = $urandom_range(0, 12288);
      endcase
      if ($urandom_range(0, 1) == 1) value = -value;
      return value[SAMPLE_BITS-1:0];
   endfunction

   // Gap after an item: mostly none, some short, a few long; bursts hold it at zero.
   function automatic int pick_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst_left = $urandom_range(30, 80);
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one sample and hold it until the block takes it; queue its expected result.
   task automatic offer_sample(input sample_type sample, input sample_type outcome);
      req_valid     <= 1'b1;
      req_sample_in <= sample;
      valid_up       = 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_samples = {expected_samples, outcome};
      items_sent++;
   endtask

   // Drop valid once; a second drop in the same step is skipped.
   task automatic drop_input();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up   = 1'b0;
      end
   endtask

   // Drop valid for a number of cycles; leave it high when no gap follows.
   task automatic rest_input(input int cycles);
      if (cycles > 0) begin
         drop_input();
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Change the curve only once every result in flight has come back.
   task automatic load_shape(input shape_type shape);
      drop_input();
      while (expected_samples.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= shape;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shape_now = shape;
      shape_writes++;
   endtask

   // Result sink: random ready with runs and stalls, plus one long hold-off
   // that the sender asks for, so the pipeline fills and pushes back.
   initial begin : result_sink
      int   run_left;
      int   stall_left;
      int   hold_left;
      logic ready_next;
      run_left   = 0;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (squeeze_request && !squeeze_done) begin
            hold_left    = SQUEEZE_CYCLES;
            squeeze_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            ready_next = 1'b1;
         end else begin
            // Mostly short runs; now and then a long stretch with no stalls.
            run_left = ($urandom_range(0, 19) == 0) ? 300 : $urandom_range(1, 24);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: stall_left = 0;
               5, 6, 7, 8:    stall_left = $urandom_range(1, 4);
               default:       stall_left = $urandom_range(15, 60);
            endcase
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin : result_check
      sample_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $error("sample_out: no result expected, actual %0d", rsp_sample_out);
            error_count++;
         end else begin
            want = expected_samples.pop_front();
            checked_count++;
            if (rsp_sample_out !== want) begin
               $error("sample_out mismatch: expected %0d, actual %0d", want, rsp_sample_out);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && !req_ready) input_stall_cycles <= input_stall_cycles + 1;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[soft_clip_waveshaper_core] ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      sample_type sample;
      shape_type  phase_shape;

      // Directed probes. Reset leaves the tanh curve selected, so the first
      // rows run without a write; zero, the three clamp, and both range ends
      // have results that can be read off directly.
      probe_table[0]  = '{SHAPE_TANH,   16'sd0,      1'b1, 16'sd0};
      probe_table[1]  = '{SHAPE_TANH,   16'sd32767,  1'b1, 16'sd4096};
      probe_table[2]  = '{SHAPE_TANH,   -16'sd32768, 1'b1, -16'sd4096};
      probe_table[3]  = '{SHAPE_TANH,   16'sd12288,  1'b1, 16'sd4096};
      probe_table[4]  = '{SHAPE_TANH,   -16'sd12288, 1'b1, -16'sd4096};
      probe_table[5]  = '{SHAPE_TANH,   16'sd12289,  1'b1, 16'sd4096};
      probe_table[6]  = '{SHAPE_TANH,   16'sd4096,   1'b0, 16'sd0};
      probe_table[7]  = '{SHAPE_TANH,   -16'sd1,     1'b0, 16'sd0};
      probe_table[8]  = '{SHAPE_TANH,   16'sd1,      1'b0, 16'sd0};
      // Cubic: at and beyond unity the curve tops out at 1 - 1/3.
      probe_table[9]  = '{SHAPE_CUBIC,  16'sd0,      1'b1, 16'sd0};
      probe_table[10] = '{SHAPE_CUBIC,  16'sd4096,   1'b1, 16'sd2731};
      probe_table[11] = '{SHAPE_CUBIC,  -16'sd4096,  1'b1, -16'sd2731};
      probe_table[12] = '{SHAPE_CUBIC,  16'sd32767,  1'b1, 16'sd2731};
      probe_table[13] = '{SHAPE_CUBIC,  -16'sd32768, 1'b1, -16'sd2731};
      probe_table[14] = '{SHAPE_CUBIC,  16'sd2048,   1'b0, 16'sd0};
      probe_table[15] = '{SHAPE_CUBIC,  -16'sd1,     1'b0, 16'sd0};
      // Hard clip around unity and at the range ends.
      probe_table[16] = '{SHAPE_HARD,   16'sd4096,   1'b1, 16'sd4096};
      probe_table[17] = '{SHAPE_HARD,   16'sd4097,   1'b1, 16'sd4096};
      probe_table[18] = '{SHAPE_HARD,   -16'sd4097,  1'b1, -16'sd4096};
      probe_table[19] = '{SHAPE_HARD,   -16'sd32768, 1'b1, -16'sd4096};
      probe_table[20] = '{SHAPE_HARD,   16'sd32767,  1'b1, 16'sd4096};
      probe_table[21] = '{SHAPE_HARD,   -16'sd123,   1'b1, -16'sd123};
      // Bypass keeps the most negative sample as it is.
      probe_table[22] = '{SHAPE_BYPASS, 16'sd32767,  1'b1, 16'sd32767};
      probe_table[23] = '{SHAPE_BYPASS, -16'sd32768, 1'b1, -16'sd32768};
      probe_table[24] = '{SHAPE_BYPASS, 16'sh5A5A,   1'b1, 16'sh5A5A};
      // Back to tanh through an explicit write.
      probe_table[25] = '{SHAPE_TANH,   -16'sd4096,  1'b0, 16'sd0};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_table[i]) begin
         if (probe_table[i].shape != shape_now) load_shape(probe_table[i].shape);
         offer_sample(probe_table[i].sample,
                      probe_table[i].typed ? probe_table[i].result
                                           : shaped_sample(shape_now, probe_table[i].sample));
         rest_input(pick_gap());
      end

      // Random phases: walk every curve once from bypass down, then pick at random.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         phase_shape = (phase < 4) ? shape_type'(3 - phase) : shape_type'($urandom_range(0, 3));
         load_shape(phase_shape);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            sample = random_sample();
            offer_sample(sample, shaped_sample(shape_now, sample));
            // Mid-phase, block the output for a long stretch and keep feeding.
            if (phase == 2 && n == 30) begin
               squeeze_request = 1'b1;
               burst_left      = 250;
            end
            rest_input(pick_gap());
         end
      end

      drop_input();
      while (expected_samples.size() != 0) @(posedge clock);
      // Hold a little past the pipeline depth to catch any stray result.
      repeat (PIPE_LATENCY + 8) @(posedge clock);

      $display("Shaped %0d samples over all four curves with %0d mode loads; %0d results checked.",
               items_sent, shape_writes, checked_count);
      $display("Input was held off for %0d cycles under output back-pressure.",
               input_stall_cycles);
      if (error_count == 0) begin
         $display("[soft_clip_waveshaper_core] OK");
      end else begin
         $display("[soft_clip_waveshaper_core] ERROR");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/scw_pkg.sv
hdl/scw_div_cell.sv
hdl/scw_front.sv
hdl/scw_out.sv
hdl/soft_clip_waveshaper_core.sv
hdl/scw_checker.sv
bench/soft_clip_waveshaper_core_tb.sv
